>>> rtl/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, character constants and alphabet mapping for the Base64 codec.
// ----------------------------------------------------------------------------
package b64_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam int unsigned RES_DEPTH = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       last;
  } res_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return CHAR_UP_A + w;
    end else if (v < 6'd52) begin
      return CHAR_LO_A + w - 8'd26;
    end else if (v < 6'd62) begin
      return CHAR_ZERO + w - 8'd52;
    end else if (v == 6'd62) begin
      return CHAR_PLUS;
    end else begin
      return CHAR_SLASH;
    end
  endfunction

  function automatic logic [5:0] dec_sextet(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd63;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      d = c - CHAR_UP_A;
    end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      d = c - CHAR_LO_A + 8'd26;
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = c - CHAR_ZERO + 8'd52;
    end else if (c == CHAR_PLUS) begin
      d = 8'd62;
    end
    return d[5:0];
  endfunction

endpackage

>>> rtl/base64_stream_codec.sv
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming Base64 encoder/decoder, standard alphabet, one item per transfer.
//
//   Channel   Dir  Handshake                   Payload
//   s_axis    in   s_axis_tvalid/tready        tdata=in_byte, tlast=last_in
//   m_axis    out  m_axis_tvalid/tready        tdata=out_byte, tuser=has_data,
//                                              tlast=last_out
//   cfg       in   cfg_valid/cfg_ready         cfg_data=mode
//
// An accepted item sits in an input register, is converted combinationally
// into up to three results in a result register, and the results leave one
// per cycle while m_axis is ready. Sustained encode rate is set by the
// single-result output port. The input register takes one more transfer while
// results wait on a stalled m_axis, then holds s_axis_tready low. Reset clears
// mode and the group state; a cfg transfer also clears the group state.
// ----------------------------------------------------------------------------
module base64_stream_codec
  import b64_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] has_data
  output logic       m_axis_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  logic       mode;
  logic [1:0] group_phase;
  logic [5:0] carried_bits;
  logic       padding_seen;

  logic       item_valid;
  logic [7:0] item_byte;
  logic       item_last;

  res_t       res [RES_DEPTH];
  logic [1:0] res_cnt;

  res_t       res_next [RES_DEPTH];
  logic [1:0] res_cnt_next;
  logic [1:0] group_phase_next;
  logic [5:0] carried_bits_next;
  logic       padding_seen_next;
  logic [5:0] sextet;
  logic       load;
  logic       cfg_fire;

  assign load = item_valid && ((res_cnt == 2'd0) || (res_cnt == 2'd1 && m_axis_tready));
  assign s_axis_tready = !item_valid || load;
  assign cfg_ready = !item_valid && (res_cnt == 2'd0);
  assign cfg_fire = cfg_valid && cfg_ready;

  assign m_axis_tvalid = (res_cnt != 2'd0);
  assign m_axis_tdata  = res[0].data;
  assign m_axis_tuser  = res[0].has_data;
  assign m_axis_tlast  = res[0].last;

  assign sextet = dec_sextet(item_byte);

  always_comb begin
    for (int i = 0; i < RES_DEPTH; i++) begin
      res_next[i] = '{data: 8'd0, has_data: 1'b1, last: 1'b0};
    end
    res_cnt_next      = 2'd0;
    group_phase_next  = group_phase;
    carried_bits_next = carried_bits;
    padding_seen_next = padding_seen;

    if (mode == MODE_ENCODE) begin
      case (group_phase)
        2'd1: begin
          res_next[0].data  = enc_char(carried_bits | {2'b00, item_byte[7:4]});
          carried_bits_next = {item_byte[3:0], 2'b00};
          group_phase_next  = 2'd2;
          res_cnt_next      = 2'd1;
          if (item_last) begin
            res_next[1].data = enc_char({item_byte[3:0], 2'b00});
            res_next[2].data = PAD_CHAR;
            res_cnt_next     = 2'd3;
          end
        end
        2'd2: begin
          res_next[0].data  = enc_char(carried_bits | {4'b0000, item_byte[7:6]});
          res_next[1].data  = enc_char(item_byte[5:0]);
          carried_bits_next = 6'd0;
          group_phase_next  = 2'd0;
          res_cnt_next      = 2'd2;
        end
        default: begin
          res_next[0].data  = enc_char(item_byte[7:2]);
          carried_bits_next = {item_byte[1:0], 4'b0000};
          group_phase_next  = 2'd1;
          res_cnt_next      = 2'd1;
          if (item_last) begin
            res_next[1].data = enc_char({item_byte[1:0], 4'b0000});
            res_next[2].data = PAD_CHAR;
            res_cnt_next     = 2'd3;
          end
        end
      endcase
    end else begin
      group_phase_next = group_phase + 2'd1;
      if (!padding_seen) begin
        case (group_phase)
          2'd0: begin
            carried_bits_next = sextet;
          end
          2'd1: begin
            res_next[0].data  = {carried_bits, sextet[5:4]};
            res_cnt_next      = 2'd1;
            carried_bits_next = sextet;
          end
          2'd2: begin
            if (item_byte == PAD_CHAR) begin
              padding_seen_next = 1'b1;
            end else begin
              res_next[0].data  = {carried_bits[3:0], sextet[5:2]};
              res_cnt_next      = 2'd1;
              carried_bits_next = sextet;
            end
          end
          default: begin
            if (item_byte == PAD_CHAR) begin
              padding_seen_next = 1'b1;
            end else begin
              res_next[0].data  = {carried_bits[1:0], sextet};
              res_cnt_next      = 2'd1;
              carried_bits_next = sextet;
            end
          end
        endcase
      end
    end

    if (item_last) begin
      if (res_cnt_next == 2'd0) begin
        res_next[0]  = '{data: 8'd0, has_data: 1'b0, last: 1'b0};
        res_cnt_next = 2'd1;
      end
      res_next[res_cnt_next - 2'd1].last = 1'b1;
      group_phase_next  = 2'd0;
      carried_bits_next = 6'd0;
      padding_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_ENCODE;
      group_phase  <= 2'd0;
      carried_bits <= 6'd0;
      padding_seen <= 1'b0;
      item_valid   <= 1'b0;
      res_cnt      <= 2'd0;
    end else begin
      if (cfg_fire) begin
        mode         <= cfg_data;
        group_phase  <= 2'd0;
        carried_bits <= 6'd0;
        padding_seen <= 1'b0;
      end else if (load) begin
        group_phase  <= group_phase_next;
        carried_bits <= carried_bits_next;
        padding_seen <= padding_seen_next;
      end

      if (s_axis_tvalid && s_axis_tready) begin
        item_valid <= 1'b1;
      end else if (load) begin
        item_valid <= 1'b0;
      end

      if (load) begin
        res_cnt <= res_cnt_next;
      end else if (m_axis_tvalid && m_axis_tready) begin
        res_cnt <= res_cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_byte <= s_axis_tdata;
      item_last <= s_axis_tlast;
    end
    if (load) begin
      for (int i = 0; i < RES_DEPTH; i++) begin
        res[i] <= res_next[i];
      end
    end else if (m_axis_tvalid && m_axis_tready) begin
      res[0] <= res[1];
      res[1] <= res[2];
    end
  end

  // An end marker always closes a message.
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("end marker without tlast");

  // A last item always yields at least one result.
  a_last_has_result: assert property (@(posedge clk) disable iff (rst)
    load && item_last |-> res_cnt_next != 2'd0)
    else $error("last item produced no result");

  // Group state is clear after a message ends.
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    load && item_last |=> group_phase == 2'd0 && carried_bits == 6'd0 && !padding_seen)
    else $error("group state not cleared after last item");

  // An empty input register always takes a transfer.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> s_axis_tready)
    else $error("input register empty but not ready");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the Base64 stream codec in both encode and decode modes. A directed
// table covers alphabet extremes, padding, end markers and a mode write that
// abandons a message; random messages follow under four idle/stall profiles.
// Each output transfer is checked against typed table rows or a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import b64_pkg::*;

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int DRAIN_CYCLES = 6;
  localparam int STALL_LIMIT  = 2000;
  localparam int SEG_ITEMS    = 20;
  localparam int DIR_ROWS     = 26;

  typedef struct packed {
    logic        is_cfg;
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic [1:0]  nres;
    logic [23:0] chars;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] in_byte
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] out_byte
  logic       m_axis_tuser;   // [0] has_data
  logic       m_axis_tlast;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;

  logic [5:0] sextet_lut [256];
  logic       mdl_mode;
  logic [1:0] grp_pos;
  logic [5:0] held_bits;
  logic       pad_hit;
  res_t       step_out [$];
  res_t       out_bytes_q [$];
  res_t       head_res;
  stim_row_t  dir_rows [DIR_ROWS];
  int         errors;
  int         src_idle;
  int         snk_stall;
  int         idle_cycles;
  logic       flip;

  base64_stream_codec dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    return ALPHABET[8*(63-int'(v)) +: 8];
  endfunction

  function automatic void emit_out(input logic [7:0] v, input logic h);
    if (step_out.size() < 3) step_out.push_back('{v, h, 1'b0});
  endfunction

  function automatic void clear_group();
    grp_pos   = 2'd0;
    held_bits = 6'd0;
    pad_hit   = 1'b0;
  endfunction

  function automatic void convert_item(input logic [7:0] b, input logic l);
    logic [5:0] s;
    logic [1:0] ph;
    res_t       r;
    step_out.delete();
    if (mdl_mode == MODE_ENCODE) begin
      case (grp_pos)
        2'd1: begin
          emit_out(b64_char(held_bits | {2'b00, b[7:4]}), 1'b1);
          held_bits = {b[3:0], 2'b00};
          grp_pos   = 2'd2;
          if (l) begin
            emit_out(b64_char(held_bits), 1'b1);
            emit_out(PAD_CHAR, 1'b1);
          end
        end
        2'd2: begin
          emit_out(b64_char(held_bits | {4'b0000, b[7:6]}), 1'b1);
          emit_out(b64_char(b[5:0]), 1'b1);
          held_bits = 6'd0;
          grp_pos   = 2'd0;
        end
        default: begin
          emit_out(b64_char(b[7:2]), 1'b1);
          held_bits = {b[1:0], 4'b0000};
          grp_pos   = 2'd1;
          if (l) begin
            emit_out(b64_char(held_bits), 1'b1);
            emit_out(PAD_CHAR, 1'b1);
            emit_out(PAD_CHAR, 1'b1);
          end
        end
      endcase
    end else begin
      s       = sextet_lut[b];
      ph      = grp_pos;
      grp_pos = grp_pos + 2'd1;
      if (!pad_hit) begin
        case (ph)
          2'd0: held_bits = s;
          2'd1: begin
            emit_out({held_bits, s[5:4]}, 1'b1);
            held_bits = s;
          end
          2'd2: begin
            if (b == PAD_CHAR) begin
              pad_hit = 1'b1;
            end else begin
              emit_out({held_bits[3:0], s[5:2]}, 1'b1);
              held_bits = s;
            end
          end
          default: begin
            if (b == PAD_CHAR) begin
              pad_hit = 1'b1;
            end else begin
              emit_out({held_bits[1:0], s}, 1'b1);
              held_bits = s;
            end
          end
        endcase
      end
    end
    if (l) begin
      if (step_out.size() == 0) step_out.push_back('{8'h00, 1'b0, 1'b0});
      r = step_out.pop_back();
      r.last = 1'b1;
      step_out.push_back(r);
      clear_group();
    end
  endfunction

  function automatic stim_row_t cfg_row(input logic m);
    return '{1'b1, {7'b0, m}, 1'b0, 1'b0, 2'd0, 24'd0};
  endfunction

  // typed rows: results carry has_data; a last row with no bytes expects the end marker
  function automatic stim_row_t hand_row(input logic [7:0] d, input logic l,
                                         input logic [1:0] n, input logic [23:0] chars);
    return '{1'b0, d, l, 1'b1, n, chars};
  endfunction

  function automatic stim_row_t pred_row(input logic [7:0] d, input logic l);
    return '{1'b0, d, l, 1'b0, 2'd0, 24'd0};
  endfunction

  task automatic send_item(input logic [7:0] d, input logic l, input logic typed,
                           input logic [1:0] n, input logic [23:0] chars);
    int k;
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = d;
    s_axis_tlast  = l;
    do @(posedge clk); while (!s_axis_tready);
    convert_item(d, l);
    if (typed) begin
      step_out.delete();
      for (k = 0; k < int'(n); k++) begin
        step_out.push_back('{chars[8*(int'(n)-1-k) +: 8], 1'b1, l && k == int'(n) - 1});
      end
      if (l && n == 2'd0) step_out.push_back('{8'h00, 1'b0, 1'b1});
    end
    foreach (step_out[j]) out_bytes_q.push_back(step_out[j]);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (out_bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = m;
    do @(posedge clk); while (!cfg_ready);
    mdl_mode = m;
    clear_group();
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_segment(input logic m);
    int         sent;
    int         len;
    int         pads;
    int         k;
    logic [7:0] c;
    write_mode(m);
    sent = 0;
    while (sent < SEG_ITEMS) begin
      if (m == MODE_ENCODE) begin
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
          send_item(8'($urandom_range(0, 255)),
                    k == len - 1 && $urandom_range(0, 7) != 0, 1'b0, 2'd0, 24'd0);
        end
      end else if ($urandom_range(0, 3) != 0) begin
        len  = 4 * $urandom_range(1, 3);
        pads = $urandom_range(0, 2);
        for (k = 0; k < len; k++) begin
          c = (k >= len - pads) ? PAD_CHAR : b64_char(6'($urandom_range(0, 63)));
          send_item(c, k == len - 1, 1'b0, 2'd0, 24'd0);
        end
      end else begin
        len = $urandom_range(1, 9);
        for (k = 0; k < len; k++) begin
          case ($urandom_range(0, 3))
            0, 1:    c = 8'($urandom_range(0, 255));
            2:       c = PAD_CHAR;
            default: c = b64_char(6'($urandom_range(0, 63)));
          endcase
          send_item(c, k == len - 1 && $urandom_range(0, 7) != 0, 1'b0, 2'd0, 24'd0);
        end
      end
      sent += len;
    end
  endtask

  always @(negedge clk) begin
    m_axis_tready = ($urandom_range(0, 99) >= snk_stall);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (out_bytes_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer data=%h user=%b last=%b",
                 $realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        head_res = out_bytes_q.pop_front();
        if (m_axis_tdata !== head_res.data || m_axis_tuser !== head_res.has_data ||
            m_axis_tlast !== head_res.last) begin
          errors++;
          $display("%0t: mismatch exp data=%h user=%b last=%b got data=%h user=%b last=%b",
                   $realtime, head_res.data, head_res.has_data, head_res.last,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = 1'b0;
    errors        = 0;
    src_idle      = 0;
    snk_stall     = 0;
    idle_cycles   = 0;
    mdl_mode      = MODE_ENCODE;
    clear_group();
    for (int i = 0; i < 256; i++) sextet_lut[i] = 6'd63;
    for (int v = 0; v < 64; v++) sextet_lut[b64_char(6'(v))] = 6'(v);

    dir_rows = '{
      cfg_row(MODE_ENCODE),
      hand_row(8'h00, 1'b1, 2'd3, "AA="),
      hand_row(8'hFF, 1'b1, 2'd3, "/w="),
      hand_row(8'h4D, 1'b0, 2'd1, "T"),
      hand_row(8'h61, 1'b0, 2'd1, "W"),
      hand_row(8'h6E, 1'b1, 2'd2, "Fu"),
      hand_row(8'h4D, 1'b0, 2'd1, "T"),
      hand_row(8'h61, 1'b1, 2'd3, "WE="),
      pred_row(8'h10, 1'b0),
      cfg_row(MODE_DECODE),
      hand_row("T", 1'b0, 2'd0, 24'd0),
      hand_row("W", 1'b0, 2'd1, "M"),
      hand_row("F", 1'b0, 2'd1, "a"),
      hand_row("u", 1'b1, 2'd1, "n"),
      hand_row("T", 1'b0, 2'd0, 24'd0),
      hand_row("Q", 1'b0, 2'd1, "M"),
      hand_row(PAD_CHAR, 1'b0, 2'd0, 24'd0),
      hand_row(PAD_CHAR, 1'b1, 2'd0, 24'd0),
      hand_row("A", 1'b1, 2'd0, 24'd0),
      pred_row(PAD_CHAR, 1'b0),
      pred_row("/", 1'b0),
      pred_row(8'h00, 1'b0),
      pred_row(8'hFF, 1'b0),
      pred_row("+", 1'b0),
      pred_row("Q", 1'b0),
      pred_row("A", 1'b1)
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_mode(dir_rows[i].data[0]);
      end else begin
        send_item(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                  dir_rows[i].nres, dir_rows[i].chars);
      end
    end

    flip = 1'($urandom_range(0, 1));
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          src_idle  = 0;
          snk_stall = 0;
        end
        1: begin
          src_idle  = 61;
          snk_stall = 0;
        end
        2: begin
          src_idle  = 0;
          snk_stall = 61;
        end
        default: begin
          src_idle  = 21;
          snk_stall = 21;
        end
      endcase
      run_segment(flip);
      run_segment(!flip);
    end

    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/b64_pkg.sv
rtl/base64_stream_codec.sv
dv/tb_top.sv
